@@ rtl/dtfp_pkg.sv @@
// shared types, codes and constants for the decimal text to fixed point converter
`timescale 1ns / 1ps

package dtfp_pkg;

   // field and datapath widths
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 63;
   localparam int SUM_W   = VALUE_W + 4;
   localparam int COUNT_W = 5;
   localparam int DIGIT_W = 4;

   // default count of fraction digits
   localparam int FRAC_DIGITS_DEFAULT = 8;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

   // saturation point of the count after the point
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // status and error codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_INVALID  = 2'd1;
   localparam status_type STATUS_FRAC_LEN = 2'd2;
   localparam status_type STATUS_OVERFLOW = 2'd3;

   // sequencer states
   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_EVAL,
      ST_SCALE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/decimal_text_to_fixed_point.sv @@
// decimal text to fixed point converter, top level
//
//  channel | direction | fields                        | handshake
//  req     | in        | char_code[7:0], last_char     | req_valid / req_ready
//  rsp     | out       | scaled_value[62:0], status[1:0] | rsp_valid / rsp_ready
//
// characters that are not the last one are gathered in the accumulate state
// after the last character the sequencer checks the status, then, if no error was
// found, scales with the shared times-ten adder once per fraction digit short of
// FRAC_DIGITS, stopping early on overflow, and then loads the result
// synchronous active high reset clears the sequencer, the number state and rsp_valid
// a stalled result holds the sequencer in its final step; characters of the next
// number are taken while an earlier result still waits
`timescale 1ns / 1ps

module decimal_text_to_fixed_point #(
   parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dtfp_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                           req_last_char,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dtfp_pkg::VALUE_W-1:0]   rsp_scaled_value,
   output logic [1:0]                     rsp_status
);

   localparam int EXP_W = $clog2(FRAC_DIGITS + 1);
   localparam int VW    = dtfp_pkg::VALUE_W;
   localparam int SW    = dtfp_pkg::SUM_W;
   localparam int CW    = dtfp_pkg::COUNT_W;

   dtfp_pkg::state_type  state_ff, state_in;
   logic [VW-1:0]        acc_ff, acc_in;
   logic                 point_ff, point_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   dtfp_pkg::status_type err_ff, err_in;
   dtfp_pkg::status_type status_ff, status_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   dtfp_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                             req_take;
   logic                             is_digit;
   logic                             is_point;
   logic [dtfp_pkg::CHAR_W-1:0]      char_off;
   logic [dtfp_pkg::DIGIT_W-1:0]     addend;
   logic [SW-1:0]                    mul_sum;
   logic                             mul_ovf;
   logic                             slot_free;
   logic                             frac_long;
   logic                             eval_fail;

   // character decode
   assign req_take = req_valid && req_ready;
   assign is_digit = (req_char_code >= dtfp_pkg::CHAR_ZERO)
                     && (req_char_code <= dtfp_pkg::CHAR_NINE);
   assign is_point = (req_char_code == dtfp_pkg::CHAR_POINT);
   assign char_off = req_char_code - dtfp_pkg::CHAR_ZERO;

   // shared times-ten adder, digit added only while gathering
   assign addend  = (state_ff == dtfp_pkg::ST_ACCUM) ? char_off[dtfp_pkg::DIGIT_W-1:0]
                                                     : '0;
   assign mul_sum = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                    + {{(SW-dtfp_pkg::DIGIT_W){1'b0}}, addend};
   assign mul_ovf = (mul_sum[SW-1:VW] != '0);

   // status checks on the finished number
   assign frac_long = point_ff && (cnt_ff > CW'(FRAC_DIGITS));
   assign eval_fail = (err_ff != dtfp_pkg::STATUS_OK) || frac_long;

   // result slot is free when empty or being taken
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtfp_pkg::ST_ACCUM: begin
            if (req_take && req_last_char) state_in = dtfp_pkg::ST_EVAL;
         end
         dtfp_pkg::ST_EVAL: begin
            state_in = eval_fail ? dtfp_pkg::ST_DONE : dtfp_pkg::ST_SCALE;
         end
         dtfp_pkg::ST_SCALE: begin
            if ((exp_ff == '0) || mul_ovf) state_in = dtfp_pkg::ST_DONE;
         end
         dtfp_pkg::ST_DONE: begin
            if (slot_free) state_in = dtfp_pkg::ST_ACCUM;
         end
         default: state_in = dtfp_pkg::ST_ACCUM;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready        = (state_ff == dtfp_pkg::ST_ACCUM);
      rsp_valid        = rsp_valid_ff;
      rsp_scaled_value = rsp_value_ff;
      rsp_status       = rsp_status_ff;
   end

   // datapath next values
   always_comb begin
      acc_in        = acc_ff;
      point_in      = point_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      status_in     = status_ff;
      exp_in        = exp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         dtfp_pkg::ST_ACCUM: begin
            if (req_take) begin
               if (is_digit) begin
                  if (mul_ovf) begin
                     if (err_ff == dtfp_pkg::STATUS_OK) err_in = dtfp_pkg::STATUS_OVERFLOW;
                  end else begin
                     acc_in = mul_sum[VW-1:0];
                  end
                  if (point_ff && (cnt_ff != dtfp_pkg::COUNT_MAX)) cnt_in = cnt_ff + 1'b1;
               end else if (is_point) begin
                  point_in = 1'b1;
                  cnt_in   = '0;
               end else begin
                  err_in = dtfp_pkg::STATUS_INVALID;
               end
            end
         end
         dtfp_pkg::ST_EVAL: begin
            // invalid character wins, then fraction length, then overflow
            if (err_ff == dtfp_pkg::STATUS_INVALID) begin
               status_in = dtfp_pkg::STATUS_INVALID;
            end else if (frac_long) begin
               status_in = dtfp_pkg::STATUS_FRAC_LEN;
            end else if (err_ff == dtfp_pkg::STATUS_OVERFLOW) begin
               status_in = dtfp_pkg::STATUS_OVERFLOW;
            end else begin
               status_in = dtfp_pkg::STATUS_OK;
            end
            exp_in = point_ff ? (EXP_W'(FRAC_DIGITS) - EXP_W'(cnt_ff)) : EXP_W'(FRAC_DIGITS);
         end
         dtfp_pkg::ST_SCALE: begin
            if (exp_ff != '0) begin
               if (mul_ovf) begin
                  status_in = dtfp_pkg::STATUS_OVERFLOW;
               end else begin
                  acc_in = mul_sum[VW-1:0];
                  exp_in = exp_ff - 1'b1;
               end
            end
         end
         dtfp_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (status_ff == dtfp_pkg::STATUS_OK) ? acc_ff : '0;
               rsp_status_in = status_ff;
               acc_in        = '0;
               point_in      = 1'b0;
               cnt_in        = '0;
               err_in        = dtfp_pkg::STATUS_OK;
               status_in     = dtfp_pkg::STATUS_OK;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // control and number state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtfp_pkg::ST_ACCUM;
         acc_ff       <= '0;
         point_ff     <= 1'b0;
         cnt_ff       <= '0;
         err_ff       <= dtfp_pkg::STATUS_OK;
         status_ff    <= dtfp_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         point_ff     <= point_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      exp_ff        <= exp_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ rtl/dtfp_checker.sv @@
// port level checker for the decimal text to fixed point converter, with its bind
`timescale 1ns / 1ps

module dtfp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_last_char,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [dtfp_pkg::VALUE_W-1:0]   rsp_scaled_value,
   input logic [1:0]                     rsp_status
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scaled_value)
                                  && $stable(rsp_status))
      else $error("stalled result word changed");

   // failed conversions report zero
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dtfp_pkg::STATUS_OK) |-> rsp_scaled_value == '0)
      else $error("nonzero value with error status");

   // input closes once the last character is taken
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_char |=> !req_ready)
      else $error("input word taken during scaling");

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last_char    (req_last_char),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_scaled_value (rsp_scaled_value),
   .rsp_status       (rsp_status)
);

@@ test/tb_top.sv @@
// testbench for the decimal text to fixed point converter, checked against its own predictor
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEFAULT;
   localparam int CHAR_W = dtfp_pkg::CHAR_W;
   localparam int VALUE_W = dtfp_pkg::VALUE_W;
   localparam logic [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic [VALUE_W-1:0]   value;
      dtfp_pkg::status_type status;
   } fixed_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                req_last_char = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_scaled_value;
   logic [1:0]          rsp_status;

   // predicted number state
   logic [63:0]                  acc_value = '0;
   logic                         acc_point = 1'b0;
   logic [dtfp_pkg::COUNT_W-1:0] acc_frac_count = '0;
   dtfp_pkg::status_type         acc_error = dtfp_pkg::STATUS_OK;

   fixed_result_type    expected_results[$];
   int                  mismatch_count = 0;
   int                  chars_sent = 0;
   bit                  no_idle = 1'b0;

   decimal_text_to_fixed_point #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .req_last_char(req_last_char),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scaled_value(rsp_scaled_value),
      .rsp_status(rsp_status)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < REPORT_LINES)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // predictor: take one character, queue the result on the last one
   task automatic convert_char(input logic [CHAR_W-1:0] code, input logic last);
      logic [63:0]      digit;
      logic [63:0]      scale;
      int               shift;
      fixed_result_type want;
      if (code >= dtfp_pkg::CHAR_ZERO && code <= dtfp_pkg::CHAR_NINE) begin
         digit = 64'(code - dtfp_pkg::CHAR_ZERO);
         if (acc_value > (VALUE_LIMIT - digit) / 64'd10) begin
            if (acc_error == dtfp_pkg::STATUS_OK)
               acc_error = dtfp_pkg::STATUS_OVERFLOW;
         end else begin
            acc_value = acc_value * 64'd10 + digit;
         end
         if (acc_point && acc_frac_count != dtfp_pkg::COUNT_MAX)
            acc_frac_count++;
      end else if (code == dtfp_pkg::CHAR_POINT) begin
         acc_point = 1'b1;
         acc_frac_count = '0;
      end else begin
         acc_error = dtfp_pkg::STATUS_INVALID;
      end
      if (last) begin
         want.value = '0;
         if (acc_error == dtfp_pkg::STATUS_INVALID) begin
            want.status = dtfp_pkg::STATUS_INVALID;
         end else if (acc_point && int'(acc_frac_count) > FRAC_DIGITS) begin
            want.status = dtfp_pkg::STATUS_FRAC_LEN;
         end else if (acc_error == dtfp_pkg::STATUS_OVERFLOW) begin
            want.status = dtfp_pkg::STATUS_OVERFLOW;
         end else begin
            // scale to the fixed count of fraction digits
            shift = acc_point ? FRAC_DIGITS - int'(acc_frac_count) : FRAC_DIGITS;
            scale = 64'd1;
            repeat (shift) scale = scale * 64'd10;
            if (acc_value > VALUE_LIMIT / scale) begin
               want.status = dtfp_pkg::STATUS_OVERFLOW;
            end else begin
               want.status = dtfp_pkg::STATUS_OK;
               want.value = VALUE_W'(acc_value * scale);
            end
         end
         expected_results.push_back(want);
         acc_value = '0;
         acc_point = 1'b0;
         acc_frac_count = '0;
         acc_error = dtfp_pkg::STATUS_OK;
      end
   endtask

   // send one character word, with an occasional gap before it
   task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      do @(posedge clock); while (!req_ready);
      convert_char(code, last);
      chars_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_char(text[i], i == text.len() - 1);
   endtask

   // hold the sender until every queued result has come back
   task automatic await_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // random number: integer part, optional fraction, maybe an extra point or a bad char
   task automatic send_random_number(input bit broken);
      logic [CHAR_W-1:0] text[$];
      int                int_len;
      int                frac_len;
      int                pick;
      int_len = ($urandom_range(99) < 12) ? $urandom_range(15, 21) : $urandom_range(0, 6);
      for (int i = 0; i < int_len; i++)
         text.push_back(dtfp_pkg::CHAR_ZERO + CHAR_W'($urandom_range(9)));
      if ($urandom_range(99) < 70) begin
         text.push_back(dtfp_pkg::CHAR_POINT);
         pick = $urandom_range(99);
         frac_len = (pick < 6) ? $urandom_range(30, 34) :
                    (pick < 25) ? $urandom_range(9, 11) : $urandom_range(0, FRAC_DIGITS);
         for (int i = 0; i < frac_len; i++)
            text.push_back(dtfp_pkg::CHAR_ZERO + CHAR_W'($urandom_range(9)));
      end
      if (text.size() == 0)
         text.push_back(($urandom_range(1) == 1) ? dtfp_pkg::CHAR_POINT
                                                 : dtfp_pkg::CHAR_ZERO + 8'd7);
      if ($urandom_range(99) < 8)
         text.insert($urandom_range(text.size()), dtfp_pkg::CHAR_POINT);
      if (broken)
         text[$urandom_range(text.size() - 1)] = CHAR_W'($urandom_range(255));
      for (int i = 0; i < text.size(); i++)
         send_char(text[i], i == text.size() - 1);
   endtask

   task automatic test_plain_numbers;
      send_text("0");
      send_text("9");
      send_text("1234567");
      send_text(".");
      send_text("0.");
      send_text(".5");
      send_text("1.2.34");
   endtask

   task automatic test_fraction_lengths;
      send_text("1.12345678");
      send_text("1.123456789");
      send_text(".00000000000000000000000000000000001");
   endtask

   task automatic test_error_codes;
      send_text("1a2");
      send_text("/");
      send_text(":");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_text("0.123456789z");
      send_text("99999999999999999999.123456789");
   endtask

   task automatic test_overflow_limits;
      send_text("92233720368");
      send_text("92233720369");
      send_text("92233720368.54775807");
      send_text("9223372036854775807");
      send_text("92233720368547758080");
      send_text("922337203685477580812");
   endtask

   task automatic test_back_to_back;
      no_idle = 1'b1;
      repeat (40) send_random_number(1'b0);
      no_idle = 1'b0;
   endtask

   task automatic test_drain_between_numbers;
      repeat (6) begin
         send_random_number(1'b0);
         await_results();
      end
   endtask

   task automatic test_random_numbers;
      while (chars_sent < 1800)
         send_random_number($urandom_range(99) < 12);
   endtask

   task automatic test_noise_chars;
      repeat (300)
         send_char(CHAR_W'($urandom_range(255)), $urandom_range(99) < 25);
   endtask

   // result side stalls
   always @(posedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      fixed_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, value", 64'(rsp_scaled_value), 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_scaled_value !== want.value)
               report_mismatch("scaled value", 64'(rsp_scaled_value), 64'(want.value));
         end
      end
   end

   // run the tests in turn
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_numbers();
      test_fraction_lengths();
      test_error_codes();
      test_overflow_limits();
      test_back_to_back();
      test_drain_between_numbers();
      test_random_numbers();
      test_noise_chars();
      await_results();
      repeat (4 * FRAC_DIGITS + 16) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("decimal_text_to_fixed_point test passed");
      else
         $display("decimal_text_to_fixed_point test failed");
      $finish;
   end

   // give up on a hung run
   initial begin
      #4_000_000;
      $display("decimal_text_to_fixed_point test failed");
      $finish;
   end

endmodule
